@@ src/tans_pkg.sv @@
`default_nettype none

package tans_pkg;

  localparam int unsigned SYMBOLS        = 256;
  localparam int unsigned PRECISION_BITS = 4;
  // power of two
  localparam int unsigned TABLE_DEPTH    = 8192;

  localparam int unsigned SYM_AW      = $clog2(SYMBOLS);
  localparam int unsigned TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned ERROR_LIMIT = 1 << (8 + PRECISION_BITS);
  localparam int unsigned SB_W        = 26;
  localparam int unsigned ST_W        = 13;

  localparam logic [ST_W-1:0] START_STATE = 13'h1fff;

  localparam logic [1:0] MODE_SIZE   = 2'd0;
  localparam logic [1:0] MODE_ENTRY  = 2'd1;
  localparam logic [1:0] MODE_ENCODE = 2'd2;
  localparam logic [1:0] MODE_FINISH = 2'd3;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_STATE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      out_byte;
    logic [ST_W-1:0] final_state;
    logic            last;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [SYM_AW-1:0] waddr;
    logic [SB_W-1:0]   wdata;
    logic              re;
    logic [SYM_AW-1:0] raddr;
  } sb_req_t;

  typedef struct packed {
    logic              we;
    logic [TAB_AW-1:0] waddr;
    logic [ST_W-1:0]   wdata;
    logic              re;
    logic [TAB_AW-1:0] raddr;
  } ns_req_t;

  function automatic logic [SYM_AW-1:0] sym_idx(input logic [7:0] sym);
    logic [31:0] w;
    w = 32'(sym) % SYMBOLS;
    return w[SYM_AW-1:0];
  endfunction

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [ST_W:0] s);
    logic [31:0] w;
    w = 32'(s) % TABLE_DEPTH;
    return w[TAB_AW-1:0];
  endfunction

  function automatic logic below_limit(input logic [ST_W-1:0] s);
    return 32'(s) < ERROR_LIMIT;
  endfunction

endpackage

`default_nettype wire

@@ src/tans_if.sv @@
`default_nettype none

interface tans_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  symbol;
  logic [12:0] index;
  logic [12:0] value;

  modport source (output valid, mode, symbol, index, value, input ready);
  modport sink (input valid, mode, symbol, index, value, output ready);
endinterface

interface tans_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [12:0] final_state;
  logic        last;

  modport source (output valid, kind, out_byte, final_state, last, input ready);
  modport sink (input valid, kind, out_byte, final_state, last, output ready);
endinterface

`default_nettype wire

@@ src/tans_ram.sv @@
`default_nettype none

module tans_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/tans_core.sv @@
`default_nettype none

module tans_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  tans_in_if.sink                              in_i,
  output tans_pkg::sb_req_t                    sb_req_o,
  input  wire logic [tans_pkg::SB_W-1:0]       sb_rdata_i,
  output tans_pkg::ns_req_t                    ns_req_o,
  input  wire logic [tans_pkg::ST_W-1:0]       ns_rdata_i,
  output logic                                 res_valid_o,
  output tans_pkg::result_t                    res_o,
  input  wire logic                            res_ready_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDSZ  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_RDNS  = 3'd3;
  localparam logic [2:0] S_FINB  = 3'd4;
  localparam logic [2:0] S_FINS  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0]                st_q, st_d;
  logic [tans_pkg::ST_W-1:0] state_q, state_d;
  logic [7:0]                buf_q, buf_d;
  logic [2:0]                cnt_q, cnt_d;
  logic                      err_q, err_d;
  logic [tans_pkg::ST_W-1:0] limit_q, limit_d;
  logic [tans_pkg::ST_W-1:0] base_q, base_d;
  logic                      pend_v_q, pend_v_d;
  tans_pkg::result_t         pend_q, pend_d;

  logic                      emit;
  logic                      go;
  tans_pkg::result_t         new_r;
  logic [7:0]                nbuf;
  logic [7:0]                pad;
  logic [tans_pkg::ST_W-1:0] sz;

  assign go   = !pend_v_q || res_ready_i;
  assign nbuf = {buf_q[6:0], state_q[0]};
  assign pad  = buf_q << (4'd8 - {1'b0, cnt_q});
  assign sz   = sb_rdata_i[tans_pkg::SB_W-1:tans_pkg::ST_W];

  always_comb begin
    st_d        = st_q;
    state_d     = state_q;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    limit_d     = limit_q;
    base_d      = base_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    emit        = 1'b0;
    new_r       = '0;
    sb_req_o    = '0;
    ns_req_o    = '0;
    res_valid_o = 1'b0;
    res_o       = pend_q;
    res_o.last  = (st_q == S_FLUSH);
    in_i.ready  = (st_q == S_IDLE);

    case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (in_i.mode)
            tans_pkg::MODE_SIZE: begin
              sb_req_o.we    = 1'b1;
              sb_req_o.waddr = tans_pkg::sym_idx(in_i.symbol);
              sb_req_o.wdata = {in_i.value, in_i.index};
            end
            tans_pkg::MODE_ENTRY: begin
              ns_req_o.we    = 1'b1;
              ns_req_o.waddr = tans_pkg::tab_addr({1'b0, in_i.index});
              ns_req_o.wdata = in_i.value;
            end
            tans_pkg::MODE_ENCODE: begin
              if (!err_q) begin
                sb_req_o.re    = 1'b1;
                sb_req_o.raddr = tans_pkg::sym_idx(in_i.symbol);
                st_d           = S_RDSZ;
              end
            end
            default: begin
              st_d = (cnt_q != 3'd0) ? S_FINB : S_FINS;
            end
          endcase
        end
      end
      S_RDSZ: begin
        limit_d = (sz == '0) ? '0 : sz - 1'b1;
        base_d  = sb_rdata_i[tans_pkg::ST_W-1:0];
        st_d    = S_SHIFT;
      end
      S_SHIFT: begin
        if (state_q > limit_q) begin
          if (cnt_q == 3'd7) begin
            emit           = 1'b1;
            new_r.kind     = tans_pkg::KIND_BYTE;
            new_r.out_byte = nbuf;
            if (go) begin
              buf_d   = '0;
              cnt_d   = '0;
              state_d = state_q >> 1;
            end
          end else begin
            buf_d   = nbuf;
            cnt_d   = cnt_q + 3'd1;
            state_d = state_q >> 1;
          end
        end else begin
          ns_req_o.re    = 1'b1;
          ns_req_o.raddr = tans_pkg::tab_addr({1'b0, base_q} + {1'b0, state_q});
          st_d           = S_RDNS;
        end
      end
      S_RDNS: begin
        if (tans_pkg::below_limit(ns_rdata_i)) begin
          emit              = 1'b1;
          new_r.kind        = tans_pkg::KIND_ERROR;
          new_r.final_state = ns_rdata_i;
          if (go) begin
            state_d = ns_rdata_i;
            err_d   = 1'b1;
            st_d    = S_FLUSH;
          end
        end else begin
          state_d = ns_rdata_i;
          st_d    = S_FLUSH;
        end
      end
      S_FINB: begin
        emit           = 1'b1;
        new_r.kind     = tans_pkg::KIND_BYTE;
        new_r.out_byte = pad;
        if (go) begin
          st_d = S_FINS;
        end
      end
      S_FINS: begin
        emit              = 1'b1;
        new_r.kind        = tans_pkg::KIND_STATE;
        new_r.final_state = state_q;
        if (go) begin
          state_d = tans_pkg::START_STATE;
          buf_d   = '0;
          cnt_d   = '0;
          err_d   = 1'b0;
          st_d    = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (pend_v_q) begin
          res_valid_o = 1'b1;
          if (res_ready_i) begin
            pend_v_d = 1'b0;
            st_d     = S_IDLE;
          end
        end else begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    // hold each result back one slot so the final one can carry last
    if (emit) begin
      res_valid_o = pend_v_q;
      if (go) begin
        pend_d   = new_r;
        pend_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      state_q  <= tans_pkg::START_STATE;
      buf_q    <= '0;
      cnt_q    <= '0;
      err_q    <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      state_q  <= state_d;
      buf_q    <= buf_d;
      cnt_q    <= cnt_d;
      err_q    <= err_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q <= limit_d;
    base_q  <= base_d;
    pend_q  <= pend_d;
  end

endmodule

`default_nettype wire

@@ src/tans_symbol_encoder.sv @@
// loads: the core stays idle with ready high, so loads can follow back to back
// encode: 0 to 13 state bits shifted out by the one-bit-per-cycle shift/compare
//   unit (held while the output stalls) between the registered table reads
// finish: a padded partial byte if any, then the final state; output stalls hold it
// reset: coder state 8191, bit buffer empty, error clear; symbol and
//   next-state tables hold nothing valid until loaded
`default_nettype none

module tans_symbol_encoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tans_in_if.sink    in_i,
  tans_out_if.source out_o
);

  tans_pkg::sb_req_t             sb_req;
  tans_pkg::ns_req_t             ns_req;
  logic [tans_pkg::SB_W-1:0]     sb_rdata;
  logic [tans_pkg::ST_W-1:0]     ns_rdata;
  logic                          res_valid;
  logic                          res_ready;
  tans_pkg::result_t             res;
  logic                          out_v_q;
  tans_pkg::result_t             out_q;

  tans_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .sb_req_o    (sb_req),
    .sb_rdata_i  (sb_rdata),
    .ns_req_o    (ns_req),
    .ns_rdata_i  (ns_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  tans_ram #(
    .WIDTH (tans_pkg::SB_W),
    .DEPTH (tans_pkg::SYMBOLS)
  ) u_sb_ram (
    .clk_i   (clk_i),
    .we_i    (sb_req.we),
    .waddr_i (sb_req.waddr),
    .wdata_i (sb_req.wdata),
    .re_i    (sb_req.re),
    .raddr_i (sb_req.raddr),
    .rdata_o (sb_rdata)
  );

  tans_ram #(
    .WIDTH (tans_pkg::ST_W),
    .DEPTH (tans_pkg::TABLE_DEPTH)
  ) u_ns_ram (
    .clk_i   (clk_i),
    .we_i    (ns_req.we),
    .waddr_i (ns_req.waddr),
    .wdata_i (ns_req.wdata),
    .re_i    (ns_req.re),
    .raddr_i (ns_req.raddr),
    .rdata_o (ns_rdata)
  );

  assign res_ready = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_ready) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.out_byte    = out_q.out_byte;
  assign out_o.final_state = out_q.final_state;
  assign out_o.last        = out_q.last;

endmodule

`default_nettype wire

@@ src/tans_checker.sv @@
`default_nettype none

module tans_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_byte,
  input wire logic [12:0] out_state,
  input wire logic        out_last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_state) && $stable(out_last))
    else $error("output word changed while stalled");

  // no new item while the current one still owes words
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready before last word");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != tans_pkg::KIND_BYTE |-> out_last)
    else $error("state or error word not last");

  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_kind == tans_pkg::KIND_BYTE) ? (out_state == 13'd0)
                                                    : (out_byte == 8'd0))
    else $error("unused field not zero");

endmodule

bind tans_symbol_encoder tans_checker u_tans_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.kind),
  .out_byte  (out_o.out_byte),
  .out_state (out_o.final_state),
  .out_last  (out_o.last)
);

`default_nettype wire

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tans_pkg::*;

  typedef struct packed {
    logic            hold;
    logic [1:0]      mode;
    logic [7:0]      symbol;
    logic [ST_W-1:0] index;
    logic [ST_W-1:0] value;
  } in_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tans_in_if  in_if ();
  tans_out_if out_if ();

  tans_symbol_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  in_word_t    send_q [$];
  result_t     due_q [$];
  int unsigned mismatches = 0;

  // encoder copy
  logic [ST_W-1:0] size_mem [SYMBOLS];
  logic [ST_W-1:0] base_mem [SYMBOLS];
  logic [ST_W-1:0] next_mem [TABLE_DEPTH];
  logic [ST_W-1:0] coder_st = START_STATE;
  logic [7:0]      pack_bits = '0;
  logic [3:0]      pack_cnt = '0;
  logic            err_seen = 1'b0;

  // what the stimulus has loaded so far, in send order
  bit          entry_set [TABLE_DEPTH];
  bit          plan_loaded [SYMBOLS];
  int unsigned plan_size [SYMBOLS];
  int unsigned plan_base [SYMBOLS];
  bit          hold_next = 1'b0;
  int unsigned word_count = 0;

  in_word_t    live_word;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned rx_draw;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;
  result_t     want;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic result_t out_word(input logic [1:0] kind, input logic [7:0] data,
                                       input logic [ST_W-1:0] st);
    result_t r;
    r.kind = kind;
    r.out_byte = data;
    r.final_state = st;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic encode_step(input in_word_t w);
    result_t         res [3];
    int              n;
    logic [ST_W-1:0] limit;
    logic [ST_W:0]   addr;
    logic [ST_W-1:0] nxt;
    n = 0;
    case (w.mode)
      MODE_SIZE: begin
        size_mem[w.symbol] = w.value;
        base_mem[w.symbol] = w.index;
      end
      MODE_ENTRY: next_mem[w.index] = w.value;
      MODE_ENCODE: begin
        if (!err_seen) begin
          limit = (size_mem[w.symbol] == '0) ? '0 : size_mem[w.symbol] - 1'b1;
          while (coder_st > limit) begin
            pack_bits = {pack_bits[6:0], coder_st[0]};
            pack_cnt = pack_cnt + 1'b1;
            if (pack_cnt == 4'd8) begin
              res[n] = out_word(KIND_BYTE, pack_bits, '0);
              n++;
              pack_bits = '0;
              pack_cnt = '0;
            end
            coder_st = coder_st >> 1;
          end
          addr = {1'b0, base_mem[w.symbol]} + {1'b0, coder_st};
          nxt = next_mem[addr[ST_W-1:0]];
          coder_st = nxt;
          if (32'(nxt) < ERROR_LIMIT) begin
            err_seen = 1'b1;
            res[n] = out_word(KIND_ERROR, '0, nxt);
            n++;
          end
        end
      end
      default: begin
        // flush partial byte, zero padded below
        if (pack_cnt != '0) begin
          res[n] = out_word(KIND_BYTE, 8'(pack_bits << (4'd8 - pack_cnt)), '0);
          n++;
        end
        res[n] = out_word(KIND_STATE, '0, coder_st);
        n++;
        coder_st = START_STATE;
        pack_bits = '0;
        pack_cnt = '0;
        err_seen = 1'b0;
      end
    endcase
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) due_q.push_back(res[i]);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, field, got, exp_val);
    mismatches++;
  endtask

  task automatic push_word(input int unsigned mode, input int unsigned sym,
                           input int unsigned idx, input int unsigned val);
    in_word_t w;
    w.hold = hold_next;
    w.mode = 2'(mode);
    w.symbol = 8'(sym);
    w.index = ST_W'(idx);
    w.value = ST_W'(val);
    hold_next = 1'b0;
    send_q.push_back(w);
    word_count++;
    if (w.mode == MODE_SIZE) begin
      plan_loaded[w.symbol] = 1'b1;
      plan_size[w.symbol] = w.value;
      plan_base[w.symbol] = w.index;
    end else if (w.mode == MODE_ENTRY) begin
      entry_set[w.index] = 1'b1;
    end
  endtask

  // every state the shift can leave must hit a loaded entry
  function automatic bit sym_ready(input int unsigned sym);
    int unsigned span;
    int unsigned j;
    if (!plan_loaded[sym]) return 1'b0;
    span = (plan_size[sym] == 0) ? 1 : plan_size[sym];
    for (j = 0; j < span; j++)
      if (!entry_set[(plan_base[sym] + j) % TABLE_DEPTH]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned draw_state();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, ERROR_LIMIT - 1);
    return $urandom_range(ERROR_LIMIT, TABLE_DEPTH - 1);
  endfunction

  function automatic int unsigned draw_size();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 12);
    if (r < 9) return $urandom_range(13, 40);
    return $urandom_range(41, 90);
  endfunction

  function automatic int unsigned draw_gap(input bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  initial begin : stimulus
    int unsigned pick, nsym, nenc, sym, sz, bs, span, k, j, t;
    int unsigned group [$];
    int unsigned known [$];

    // size zero with base at the top, landing on entry 8191
    push_word(MODE_SIZE, 0, 8191, 0);
    push_word(MODE_ENTRY, 255, 8191, 8191);
    push_word(MODE_SIZE, 255, 0, 8191);
    push_word(MODE_ENTRY, 0, 4095, ERROR_LIMIT);
    push_word(MODE_SIZE, 1, 100, 4097);
    push_word(MODE_ENTRY, 0, 4196, ERROR_LIMIT - 1);
    push_word(MODE_ENCODE, 0, 0, 0);
    push_word(MODE_ENCODE, 255, 8191, 8191);
    // no shift, next state just below the limit
    push_word(MODE_ENCODE, 1, 0, 0);
    push_word(MODE_ENCODE, 0, 0, 0);
    push_word(MODE_FINISH, 0, 0, 0);
    push_word(MODE_FINISH, 255, 8191, 8191);
    push_word(MODE_ENTRY, 0, 0, 0);
    push_word(MODE_SIZE, 2, 0, 1);
    push_word(MODE_ENCODE, 2, 0, 0);
    push_word(MODE_FINISH, 0, 0, 0);
    push_word(MODE_ENCODE, 0, 0, 0);
    push_word(MODE_ENCODE, 0, 0, 0);
    push_word(MODE_SIZE, 3, 5000, 2);
    push_word(MODE_ENTRY, 0, 5000, 6000);
    push_word(MODE_ENTRY, 0, 5001, ERROR_LIMIT);
    push_word(MODE_ENCODE, 3, 0, 0);
    push_word(MODE_ENCODE, 3, 0, 0);
    push_word(MODE_FINISH, 0, 0, 0);
    known.push_back(0);
    known.push_back(3);

    hold_next = 1'b1;
    while (word_count < 436) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        group.delete();
        nsym = $urandom_range(1, 4);
        for (k = 0; k < nsym; k++) begin
          sym = $urandom_range(0, 255);
          sz = draw_size();
          bs = $urandom_range(0, TABLE_DEPTH - 1);
          push_word(MODE_SIZE, sym, bs, sz);
          span = (sz == 0) ? 1 : sz;
          for (j = 0; j < span; j++)
            if (!entry_set[(bs + j) % TABLE_DEPTH] || $urandom_range(0, 3) == 0)
              push_word(MODE_ENTRY, $urandom, (bs + j) % TABLE_DEPTH, draw_state());
          group.push_back(sym);
          known.push_back(sym);
        end
        nenc = $urandom_range(2, 14);
        for (k = 0; k < nenc; k++) begin
          sym = group[$urandom_range(0, group.size() - 1)];
          if (sym_ready(sym)) push_word(MODE_ENCODE, sym, $urandom, $urandom);
        end
        if ($urandom_range(0, 4) != 0) begin
          hold_next = ($urandom_range(0, 3) == 0);
          push_word(MODE_FINISH, $urandom, $urandom, $urandom);
        end
      end else if (pick == 7) begin
        nenc = $urandom_range(1, 4);
        for (k = 0; k < nenc; k++) begin
          t = $urandom_range(0, 3);
          sym = $urandom_range(0, 255);
          if (t == 0) push_word(MODE_SIZE, sym, $urandom, $urandom);
          else if (t == 2 && sym_ready(sym)) push_word(MODE_ENCODE, sym, $urandom, $urandom);
          else if (t == 3) push_word(MODE_FINISH, sym, $urandom, $urandom);
          else push_word(MODE_ENTRY, sym, $urandom, $urandom);
        end
      end else begin
        nenc = $urandom_range(1, 10);
        for (k = 0; k < nenc; k++) begin
          sym = known[$urandom_range(0, known.size() - 1)];
          if (sym_ready(sym)) push_word(MODE_ENCODE, sym, $urandom, $urandom);
        end
        if ($urandom_range(0, 1) == 0) push_word(MODE_FINISH, $urandom, $urandom, $urandom);
      end
    end

    while (send_q.size() != 0 || in_if.valid || due_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && due_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.mode <= MODE_SIZE;
      in_if.symbol <= '0;
      in_if.index <= '0;
      in_if.value <= '0;
      send_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        encode_step(live_word);
        if ($urandom_range(0, 29) == 0) calm_tx = !calm_tx;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (send_q.size() != 0 && !(send_q[0].hold && due_q.size() != 0)) begin
          live_word = send_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.mode <= live_word.mode;
          in_if.symbol <= live_word.symbol;
          in_if.index <= live_word.index;
          in_if.value <= live_word.value;
          send_gap <= draw_gap(calm_tx);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap <= 0;
    end else if (out_if.valid && out_if.ready) begin
      if (due_q.size() == 0) begin
        note_mismatch("unexpected word, kind", 32'(out_if.kind), 0);
      end else begin
        want = due_q.pop_front();
        if (out_if.kind !== want.kind)
          note_mismatch("kind", 32'(out_if.kind), 32'(want.kind));
        if (out_if.out_byte !== want.out_byte)
          note_mismatch("out_byte", 32'(out_if.out_byte), 32'(want.out_byte));
        if (out_if.final_state !== want.final_state)
          note_mismatch("final_state", 32'(out_if.final_state), 32'(want.final_state));
        if (out_if.last !== want.last)
          note_mismatch("last", 32'(out_if.last), 32'(want.last));
      end
      if ($urandom_range(0, 29) == 0) calm_rx = !calm_rx;
      rx_draw = draw_gap(calm_rx);
      if (rx_draw == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        recv_gap <= rx_draw;
      end
    end else if (recv_gap > 1) begin
      recv_gap <= recv_gap - 1;
    end else begin
      recv_gap <= 0;
      out_if.ready <= 1'b1;
    end
  end

endmodule
